/* rtl/core/pfra_pkg.sv */
// Shared types and constants of the page frame reference-count allocator.
package pfra_pkg;

    localparam int FRAME_W = 36;
    localparam int COUNT_W = 11;
    localparam int ADDR_W  = 48;
    localparam int STAT_W  = 3;
    localparam int OP_W    = 2;

    localparam int DIV_STEPS  = FRAME_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_RETAIN  = 2'd2;
    localparam logic [OP_W-1:0] OP_SPARE   = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_NO_MEMORY = 3'd1;
    localparam logic [STAT_W-1:0] ST_OUTSIDE   = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOT_ALLOC = 3'd3;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd4;

    localparam logic CFG_BASE_FRAME = 1'b0;
    localparam logic CFG_ZONE_PAGES = 1'b1;

    typedef struct packed {
        logic [OP_W-1:0]    opcode;
        logic [COUNT_W-1:0] page_count;
        logic               align_request;
        logic [ADDR_W-1:0]  address;
    } in_item_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ADDR_W-1:0] result_address;
    } out_item_t;

endpackage

/* rtl/core/pfra_ref_mem.sv */
// Reference-count memory: one write port and one read port with registered read data.
module pfra_ref_mem
    import pfra_pkg::*;
#(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 8,
    parameter int AW     = 10
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [AW-1:0]     raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/pfra_rem_unit.sv */
// Restoring remainder unit: frame number modulo run length, one bit per cycle.
module pfra_rem_unit
    import pfra_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [FRAME_W-1:0] dividend,
    input  logic [COUNT_W-1:0] divisor,
    output logic               done,
    output logic [COUNT_W-1:0] rem
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [FRAME_W-1:0]   sh_reg, sh_next;
    logic [COUNT_W-1:0]   rem_reg, rem_next;
    logic [COUNT_W-1:0]   div_reg, div_next;
    logic [COUNT_W:0]     trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        trial     = {rem_reg, sh_reg[FRAME_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            sh_next   = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                trial = trial - {1'b0, div_reg};
            end
            rem_next = trial[COUNT_W-1:0];
            sh_next  = {sh_reg[FRAME_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

/* rtl/core/page_frame_refcount_allocator.sv */
// Top level of the page frame reference-count allocator: sequencer, registers, result stage.
//
// Usage: requests arrive on in_valid / in_stall / in_data, one transfer per
// request, and every request yields exactly one result transfer on
// out_valid / out_stall / out_data. The user must set the zone through the
// plain write port (cfg_we, cfg_index, cfg_data) only while no request is
// in progress; the block itself does not enforce this. Allocate takes a
// decode step, a remainder computation when alignment is asked, then a scan
// of the pages from page 0 up to the end of the chosen run, then a write of
// the count of each allocated page. Release and retain take a range check,
// then a pass that verifies every page and a pass that updates them. The
// single read port of the count memory limits these passes: one page is
// read per cycle. The result is then handed to the output register once
// that register is free. Requests are taken one at a time. After reset the
// block clears all MAX_PAGES counts, one per cycle, and holds in_stall high
// until that sweep is done; the zone registers reset to zero. A finished
// result waits in the output register while the receiver stalls; a new
// request is still taken, and it only waits at its own end.
module page_frame_refcount_allocator
    import pfra_pkg::*;
#(
    parameter int MAX_PAGES  = 1024,
    parameter int REF_BITS   = 8,
    parameter int PAGE_SHIFT = 12
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  in_item_t           in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output out_item_t          out_data,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [FRAME_W-1:0] cfg_data
);

    localparam int PG_W  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int NC_W  = $clog2(MAX_PAGES + 1);
    localparam int CW    = (NC_W > COUNT_W) ? NC_W : COUNT_W;
    localparam int BW    = (ADDR_W > FRAME_W + PAGE_SHIFT) ? ADDR_W : FRAME_W + PAGE_SHIFT;
    localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_MOD    = 9'b000000100,
        S_SCAN   = 9'b000001000,
        S_FILL   = 9'b000010000,
        S_RANGE  = 9'b000100000,
        S_CHECK  = 9'b001000000,
        S_UPDATE = 9'b010000000,
        S_FINISH = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // Zone registers.
    logic [FRAME_W-1:0] base_frame_reg;
    logic [COUNT_W-1:0] zone_pages_reg;

    // Latched request.
    logic [OP_W-1:0]    op_reg, op_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic               align_reg, align_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;

    // Walk pointers: rd issues reads, ev follows in the next cycle.
    logic [CW-1:0]      rd_idx_reg, rd_idx_next;
    logic [CW-1:0]      ev_idx_reg, ev_idx_next;
    logic [CW-1:0]      lim_reg, lim_next;
    logic [CW-1:0]      start_reg, start_next;
    logic [CW-1:0]      len_reg, len_next;
    logic               pend_reg, pend_next;
    logic [COUNT_W-1:0] rem_reg, rem_next;

    // Pending result and output stage.
    logic [STAT_W-1:0]  res_status_reg, res_status_next;
    logic [ADDR_W-1:0]  res_addr_reg, res_addr_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_data_reg, out_data_next;

    // Memory and remainder unit hookups.
    logic                mem_we;
    logic [PG_W-1:0]     mem_waddr;
    logic [REF_BITS-1:0] mem_wdata;
    logic [PG_W-1:0]     mem_raddr;
    logic [REF_BITS-1:0] mem_rdata;
    logic                div_start;
    logic                div_done;
    logic [COUNT_W-1:0]  div_rem;

    // Derived zone values.
    logic [CW-1:0]      live_pages;
    logic [CW-1:0]      zone_ext;
    logic [BW-1:0]      base_byte;
    logic [BW-1:0]      addr_ext;
    logic [BW-1:0]      first_w;
    logic [BW-1:0]      n_ext;
    logic               outside;
    logic               issue;
    logic               slot_free;
    logic               aligned_ok;
    logic [CW-1:0]      len_new;
    logic [COUNT_W:0]   rem_inc;

    assign zone_ext   = CW'(zone_pages_reg);
    assign live_pages = (zone_ext > CW'(MAX_PAGES)) ? CW'(MAX_PAGES) : zone_ext;
    assign base_byte  = BW'(base_frame_reg) << PAGE_SHIFT;
    assign addr_ext   = BW'(addr_reg);
    assign first_w    = (addr_ext - base_byte) >> PAGE_SHIFT;
    assign n_ext      = BW'(live_pages);
    assign outside    = (addr_ext < base_byte) || (first_w >= n_ext)
                        || (BW'(cnt_reg) > n_ext - first_w);
    assign issue      = rd_idx_reg < lim_reg;
    assign slot_free  = !out_valid_reg || !out_stall;
    assign aligned_ok = !align_reg || (rem_reg == '0);
    assign rem_inc    = {1'b0, rem_reg} + 1'b1;

    pfra_ref_mem #(
        .DEPTH  (MAX_PAGES),
        .DATA_W (REF_BITS),
        .AW     (PG_W)
    ) u_ref_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // The divider starts in the accepting cycle, so it takes the count from the request.
    pfra_rem_unit u_rem_unit (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (base_frame_reg),
        .divisor  (in_data.page_count),
        .done     (div_done),
        .rem      (div_rem)
    );

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        cnt_next        = cnt_reg;
        align_next      = align_reg;
        addr_next       = addr_reg;
        rd_idx_next     = rd_idx_reg;
        ev_idx_next     = ev_idx_reg;
        lim_next        = lim_reg;
        start_next      = start_reg;
        len_next        = len_reg;
        pend_next       = pend_reg;
        rem_next        = rem_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_data_next   = out_data_reg;
        mem_we          = 1'b0;
        mem_waddr       = ev_idx_reg[PG_W-1:0];
        mem_wdata       = '0;
        mem_raddr       = rd_idx_reg[PG_W-1:0];
        div_start       = 1'b0;
        len_new         = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                // Power-up sweep: every count returns to zero.
                mem_we      = 1'b1;
                mem_waddr   = rd_idx_reg[PG_W-1:0];
                mem_wdata   = '0;
                rd_idx_next = rd_idx_reg + 1'b1;
                if (rd_idx_reg == CW'(MAX_PAGES - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next         = in_data.opcode;
                    cnt_next        = in_data.page_count;
                    align_next      = in_data.align_request;
                    addr_next       = in_data.address;
                    res_addr_next   = '0;
                    rd_idx_next     = '0;
                    ev_idx_next     = '0;
                    lim_next        = live_pages;
                    len_next        = '0;
                    pend_next       = 1'b0;
                    rem_next        = '0;
                    unique case (in_data.opcode)
                        OP_ALLOC:
                        begin
                            if ((in_data.page_count == '0)
                                || (CW'(in_data.page_count) > live_pages))
                            begin
                                res_status_next = ST_NO_MEMORY;
                                state_next      = S_FINISH;
                            end
                            else if (in_data.align_request)
                            begin
                                div_start  = 1'b1;
                                state_next = S_MOD;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_RELEASE, OP_RETAIN:
                        begin
                            state_next = S_RANGE;
                        end
                        default:
                        begin
                            res_status_next = ST_OK;
                            state_next      = S_FINISH;
                        end
                    endcase
                end
            end

            S_MOD:
            begin
                // Starting page is aligned when (base frame + page) mod count is zero.
                if (div_done)
                begin
                    rem_next   = div_rem;
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                pend_next = issue;
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    ev_idx_next = ev_idx_reg + 1'b1;
                    rem_next    = (rem_inc == {1'b0, cnt_reg}) ? '0 : rem_inc[COUNT_W-1:0];
                    if (mem_rdata == '0)
                    begin
                        if (len_reg != '0)
                        begin
                            len_new = len_reg + 1'b1;
                        end
                        else if (aligned_ok)
                        begin
                            len_new    = CW'(1);
                            start_next = ev_idx_reg;
                        end
                    end
                    len_next = len_new;
                    if (len_new == CW'(cnt_reg))
                    begin
                        // Run found: write its counts starting at the run's first page.
                        ev_idx_next = (len_reg == '0) ? ev_idx_reg : start_reg;
                        lim_next    = ((len_reg == '0) ? ev_idx_reg : start_reg)
                                      + CW'(cnt_reg);
                        state_next  = S_FILL;
                    end
                end
                else if (!issue)
                begin
                    res_status_next = ST_NO_MEMORY;
                    state_next      = S_FINISH;
                end
            end

            S_FILL:
            begin
                mem_we      = 1'b1;
                mem_wdata   = REF_BITS'(1);
                ev_idx_next = ev_idx_reg + 1'b1;
                if (ev_idx_reg + 1'b1 == lim_reg)
                begin
                    res_status_next = ST_OK;
                    res_addr_next   = ADDR_W'(base_byte + (BW'(start_reg) << PAGE_SHIFT));
                    state_next      = S_FINISH;
                end
            end

            S_RANGE:
            begin
                if (outside)
                begin
                    res_status_next = ST_OUTSIDE;
                    state_next      = S_FINISH;
                end
                else if (cnt_reg == '0)
                begin
                    res_status_next = ST_OK;
                    state_next      = S_FINISH;
                end
                else
                begin
                    start_next  = first_w[CW-1:0];
                    rd_idx_next = first_w[CW-1:0];
                    ev_idx_next = first_w[CW-1:0];
                    lim_next    = first_w[CW-1:0] + CW'(cnt_reg);
                    pend_next   = 1'b0;
                    state_next  = S_CHECK;
                end
            end

            S_CHECK:
            begin
                // Whole range is verified before any count changes.
                pend_next = issue;
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    ev_idx_next = ev_idx_reg + 1'b1;
                    if ((op_reg == OP_RELEASE) && (mem_rdata == '0))
                    begin
                        res_status_next = ST_NOT_ALLOC;
                        state_next      = S_FINISH;
                    end
                    else if ((op_reg == OP_RETAIN) && (mem_rdata == REF_MAX))
                    begin
                        res_status_next = ST_OVERFLOW;
                        state_next      = S_FINISH;
                    end
                end
                else if (!issue)
                begin
                    rd_idx_next = start_reg;
                    ev_idx_next = start_reg;
                    pend_next   = 1'b0;
                    state_next  = S_UPDATE;
                end
            end

            S_UPDATE:
            begin
                // Read one page ahead while the previous page is written back.
                pend_next = issue;
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    mem_we      = 1'b1;
                    mem_wdata   = (op_reg == OP_RELEASE) ? mem_rdata - 1'b1
                                                         : mem_rdata + 1'b1;
                    ev_idx_next = ev_idx_reg + 1'b1;
                end
                else if (!issue)
                begin
                    res_status_next = ST_OK;
                    state_next      = S_FINISH;
                end
            end

            S_FINISH:
            begin
                if (slot_free)
                begin
                    out_valid_next               = 1'b1;
                    out_data_next.status         = res_status_reg;
                    out_data_next.result_address =
                        (res_status_reg == ST_OK) ? res_addr_reg : '0;
                    state_next                   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            rd_idx_reg     <= '0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            base_frame_reg <= '0;
            zone_pages_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_idx_reg    <= rd_idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_BASE_FRAME: base_frame_reg <= cfg_data;
                    CFG_ZONE_PAGES: zone_pages_reg <= cfg_data[COUNT_W-1:0];
                    default:        base_frame_reg <= base_frame_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        cnt_reg        <= cnt_next;
        align_reg      <= align_next;
        addr_reg       <= addr_next;
        ev_idx_reg     <= ev_idx_next;
        lim_reg        <= lim_next;
        start_reg      <= start_next;
        len_reg        <= len_next;
        rem_reg        <= rem_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        out_data_reg   <= out_data_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTH
    // Counts change only while a sweep, a fill or an update is running.
    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_CLEAR || state_reg == S_FILL || state_reg == S_UPDATE))
        else $error("count memory written outside a write phase");

    // A fresh allocation always writes a count of one.
    a_fill_one: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL) |-> (mem_we && mem_wdata == REF_BITS'(1)))
        else $error("allocation fill wrote a count other than one");

    // The evaluated page always trails the issued read.
    a_walk_order: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg && (state_reg == S_SCAN || state_reg == S_CHECK || state_reg == S_UPDATE))
        |-> (ev_idx_reg < rd_idx_reg))
        else $error("read pipeline lost track of the evaluated page");

    // A failed request never reports an address.
    a_err_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status != ST_OK) |-> (out_data.result_address == '0))
        else $error("error result carries a nonzero address");
`endif

endmodule

/* tb/page_frame_refcount_allocator_test.sv */
// Self-checking testbench for the page frame reference-count allocator, with its own predictor.
module page_frame_refcount_allocator_test;
    import pfra_pkg::*;

    localparam int MAX_PAGES  = 1024;
    localparam int REF_BITS   = 8;
    localparam int PAGE_SHIFT = 12;
    localparam logic [REF_BITS-1:0] REF_FULL = '1;
    // Longest quiet stretch: a full-zone allocate or a 1024-page range walk,
    // the reset clearing pass, and the receiver's longest stall, with margin.
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 50;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    in_item_t           in_data;
    logic               out_valid;
    logic               out_stall;
    out_item_t          out_data;
    logic               cfg_we;
    logic               cfg_index;
    logic [FRAME_W-1:0] cfg_data;

    page_frame_refcount_allocator #(
        .MAX_PAGES (MAX_PAGES),
        .REF_BITS  (REF_BITS),
        .PAGE_SHIFT(PAGE_SHIFT)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Shadow copy of the zone registers and of every page's reference count.
    logic [FRAME_W-1:0]  zone_base;
    logic [COUNT_W-1:0]  zone_size;
    logic [REF_BITS-1:0] ref_counts [MAX_PAGES];

    // Results that the block still owes, oldest first.
    out_item_t pending_results [$];

    // Runs handed out by the block, used to build well-formed release and retain requests.
    typedef struct {
        logic [ADDR_W-1:0] addr;
        int                pages;
    } run_t;
    run_t granted_runs [$];

    int  error_count;
    bit  quiet;      // when set, neither side inserts gaps or stalls
    int  idle_cycles;

    // Clock: period of 10 time units.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor. It follows the block's rules: allocate is first fit from
    // page 0 over the live part of the zone, and a range request checks all
    // of its pages before any count is touched.
    // ------------------------------------------------------------------
    function automatic int live_size();
        return (zone_size > MAX_PAGES) ? MAX_PAGES : int'(zone_size);
    endfunction

    function automatic logic [63:0] zone_byte_base();
        return 64'(zone_base) << PAGE_SHIFT;
    endfunction

    function automatic out_item_t predict_allocate(int pages, bit aligned);
        out_item_t   res;
        int          n;
        int          free_run [MAX_PAGES + 1];
        logic [63:0] pa;
        logic [63:0] run_bytes;
        n = live_size();
        res.status = ST_NO_MEMORY;
        res.result_address = '0;
        if (pages == 0 || pages > n)
            return res;
        run_bytes = 64'(pages) << PAGE_SHIFT;
        // Length of the free run that starts at each page.
        free_run[n] = 0;
        for (int i = n - 1; i >= 0; i--)
            free_run[i] = (ref_counts[i] == '0) ? free_run[i + 1] + 1 : 0;
        for (int i = 0; i + pages <= n; i++)
        begin
            pa = zone_byte_base() + (64'(i) << PAGE_SHIFT);
            if (aligned && (pa % run_bytes) != 0)
                continue;
            if (free_run[i] >= pages)
            begin
                for (int k = 0; k < pages; k++)
                    ref_counts[i + k] = 1;
                res.status = ST_OK;
                res.result_address = pa[ADDR_W-1:0];
                return res;
            end
        end
        return res;
    endfunction

    function automatic logic [STAT_W-1:0] predict_range(logic [ADDR_W-1:0] addr, int pages,
                                                        bit releasing);
        logic [63:0] first;
        int          n;
        n = live_size();
        if (64'(addr) < zone_byte_base())
            return ST_OUTSIDE;
        first = (64'(addr) - zone_byte_base()) >> PAGE_SHIFT;
        if (first >= 64'(n) || 64'(pages) > 64'(n) - first)
            return ST_OUTSIDE;
        for (int k = 0; k < pages; k++)
        begin
            if (releasing && ref_counts[int'(first) + k] == '0)
                return ST_NOT_ALLOC;
            if (!releasing && ref_counts[int'(first) + k] == REF_FULL)
                return ST_OVERFLOW;
        end
        for (int k = 0; k < pages; k++)
            ref_counts[int'(first) + k] += releasing ? -1 : 1;
        return ST_OK;
    endfunction

    function automatic out_item_t predict_result(in_item_t item);
        out_item_t res;
        res.status = ST_OK;
        res.result_address = '0;
        case (item.opcode)
            OP_ALLOC:   res = predict_allocate(int'(item.page_count), item.align_request);
            OP_RELEASE: res.status = predict_range(item.address, int'(item.page_count), 1'b1);
            OP_RETAIN:  res.status = predict_range(item.address, int'(item.page_count), 1'b0);
            default:    ; // the spare opcode does nothing and answers ok
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Gap lengths: mostly none or short, now and then a long one.
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Sends one request and returns the result the predictor expects for it.
    // Inputs change at the falling edge; acceptance is judged at the rising edge.
    task automatic send_request(input in_item_t item, output out_item_t predicted);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data  = item;
        in_valid = 1'b1;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        predicted = predict_result(item);
        pending_results.push_back(predicted);
        if (item.opcode == OP_ALLOC && predicted.status == ST_OK)
            granted_runs.push_back('{predicted.result_address, int'(item.page_count)});
    endtask

    task automatic issue(input logic [OP_W-1:0] op, input int pages, input bit aligned,
                         input logic [ADDR_W-1:0] addr);
        in_item_t  item;
        out_item_t predicted;
        item.opcode        = op;
        item.page_count    = COUNT_W'(pages);
        item.align_request = aligned;
        item.address       = addr;
        send_request(item, predicted);
    endtask

    // Holds the request side until every owed result has come back.
    task automatic wait_until_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        // Every request yields a result, so nothing can still be in flight;
        // a few cycles let the result stage settle before the registers change.
        repeat (4) @(negedge clk);
    endtask

    // Register writes happen only while the block is idle.
    task automatic write_zone(input logic [FRAME_W-1:0] base, input logic [COUNT_W-1:0] pages);
        wait_until_drained();
        cfg_we    = 1'b1;
        cfg_index = CFG_BASE_FRAME;
        cfg_data  = base;
        @(negedge clk);
        cfg_index = CFG_ZONE_PAGES;
        cfg_data  = FRAME_W'(pages);
        @(negedge clk);
        cfg_we    = 1'b0;
        zone_base = base;
        zone_size = pages;
        granted_runs.delete();
    endtask

    function automatic logic [ADDR_W-1:0] page_addr(int page);
        logic [63:0] a;
        a = zone_byte_base() + (64'(page) << PAGE_SHIFT);
        return a[ADDR_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Special cases on a 16-page zone.
    task automatic test_directed();
        write_zone(36'h10, 11'd16);
        issue(OP_ALLOC, 0, 1'b0, '0);               // empty allocate
        issue(OP_ALLOC, 17, 1'b0, '0);              // larger than the zone
        issue(OP_ALLOC, 1, 1'b0, '0);               // page 0
        issue(OP_ALLOC, 4, 1'b1, '0);               // aligned run of four
        issue(OP_ALLOC, 16, 1'b0, '0);              // no fitting run
        issue(OP_ALLOC, 3, 1'b0, '1);               // fills the gap left by alignment
        issue(OP_RELEASE, 1, 1'b0, page_addr(0) + 48'hABC);   // unaligned address
        issue(OP_RELEASE, 1, 1'b0, page_addr(0));   // release of a free page
        issue(OP_RELEASE, 1, 1'b0, page_addr(0) - 1);         // below the zone
        issue(OP_RETAIN, 2, 1'b0, page_addr(15));   // runs past the last page
        issue(OP_RETAIN, 0, 1'b0, page_addr(15));   // empty range inside the zone
        issue(OP_RELEASE, 0, 1'b0, page_addr(16));  // empty range just past the zone
        issue(OP_RETAIN, 1, 1'b0, page_addr(12));   // retain of a free page
        issue(OP_RELEASE, 1, 1'b0, page_addr(12));
        issue(OP_RETAIN, 2047, 1'b1, '1);           // every bit set
        issue(OP_RELEASE, 2047, 1'b0, '1);
        issue(OP_SPARE, 5, 1'b1, page_addr(1));     // spare opcode
        issue(OP_ALLOC, 16, 1'b1, '0);
    endtask

    // Drives two pages to the largest count, then one step further.
    task automatic test_saturation();
        quiet = 1'b1;
        write_zone(36'h0, 11'd4);
        issue(OP_ALLOC, 2, 1'b0, '0);
        for (int i = 1; i < int'(REF_FULL); i++)
            issue(OP_RETAIN, 2, 1'b0, page_addr(0));
        issue(OP_RETAIN, 1, 1'b0, page_addr(1));    // overflows
        issue(OP_RELEASE, 1, 1'b0, page_addr(0));
        issue(OP_RETAIN, 1, 1'b0, page_addr(0));    // fits again
        quiet = 1'b0;
    endtask

    // Register extremes: the highest base frame truncates the result address,
    // an oversized zone acts as the full store, and an empty zone refuses all.
    task automatic test_zone_extremes();
        write_zone('1, '1);
        issue(OP_ALLOC, 1024, 1'b0, '0);
        issue(OP_ALLOC, 1, 1'b0, '0);
        issue(OP_RETAIN, 1024, 1'b0, page_addr(0));
        issue(OP_RELEASE, 1024, 1'b0, page_addr(0));
        issue(OP_RELEASE, 1024, 1'b0, page_addr(0));
        write_zone('0, '0);
        issue(OP_ALLOC, 1, 1'b0, '0);
        issue(OP_RETAIN, 0, 1'b0, '0);
        write_zone(36'h3, 11'd1024);
        issue(OP_ALLOC, 1024, 1'b0, '0);
        issue(OP_RELEASE, 1024, 1'b0, page_addr(0));
    endtask

    // Pages beyond a lowered zone keep their counts and show again on growth.
    task automatic test_zone_shrink();
        write_zone(36'h40, 11'd32);
        issue(OP_ALLOC, 32, 1'b0, '0);
        write_zone(36'h40, 11'd8);
        issue(OP_RELEASE, 8, 1'b0, page_addr(0));
        issue(OP_RETAIN, 1, 1'b0, page_addr(20));
        issue(OP_ALLOC, 8, 1'b1, '0);
        write_zone(36'h40, 11'd32);
        issue(OP_ALLOC, 4, 1'b0, '0);
        issue(OP_RELEASE, 24, 1'b0, page_addr(8));
    endtask

    // Random requests on one zone: allocations, release and retain traffic on
    // runs that the block handed out, ranges near the zone edges, and noise with random fields.
    task automatic test_random_zone(input logic [FRAME_W-1:0] base,
                                    input logic [COUNT_W-1:0] pages, input int items);
        int    n;
        int    r;
        int    pick;
        int    span;
        int    offset;
        run_t  run;
        write_zone(base, pages);
        n = live_size();
        for (int i = 0; i < items; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 35 || granted_runs.size() == 0)
            begin
                span = ($urandom_range(0, 9) == 0) ? $urandom_range(1, n + 1)
                                                   : $urandom_range(1, 8);
                issue(OP_ALLOC, span, 1'($urandom_range(0, 1)), ADDR_W'({$urandom, $urandom}));
            end
            else if (r < 85)
            begin
                pick = $urandom_range(0, granted_runs.size() - 1);
                run  = granted_runs[pick];
                offset = $urandom_range(0, run.pages - 1);
                span   = $urandom_range(0, run.pages - offset);
                issue(($urandom_range(0, 1) != 0) ? OP_RELEASE : OP_RETAIN, span, 1'b0,
                      run.addr + ADDR_W'(offset << PAGE_SHIFT)
                      + ADDR_W'($urandom_range(0, (1 << PAGE_SHIFT) - 1)));
                if ($urandom_range(0, 3) == 0)
                    granted_runs.delete(pick);
            end
            else if (r < 95)
            begin
                // Ranges near the zone edges.
                issue(OP_W'($urandom_range(1, 2)), $urandom_range(0, 4), 1'b0,
                      page_addr($urandom_range(0, 1) ? n - $urandom_range(0, 2)
                                                     : $urandom_range(0, 2))
                      - ADDR_W'($urandom_range(0, 1)));
            end
            else
            begin
                issue(OP_W'($urandom_range(0, 3)), $urandom_range(0, 2047),
                      1'($urandom_range(0, 1)), ADDR_W'({$urandom, $urandom}));
            end
        end
    endtask

    task automatic test_random();
        test_random_zone(36'h0, 11'd16, 45);
        test_random_zone(FRAME_W'({$urandom, $urandom}), 11'd64, 50);
        // Hold the request side once until everything owed has come back.
        wait_until_drained();
        test_random_zone(36'h5, 11'd1, 20);
        quiet = 1'b1;
        test_random_zone(FRAME_W'($urandom_range(0, 255)), 11'd200, 50);
        quiet = 1'b0;
        test_random_zone(36'h800, 11'd37, 50);
        test_random_zone(FRAME_W'({$urandom, $urandom}), 11'd1024, 30);
        test_random_zone(36'h7, 11'd1500, 20);
        test_random_zone('1, 11'd24, 40);
    endtask

    // ------------------------------------------------------------------
    // Receiver: stalls in bursts of random length, or not at all when quiet.
    // ------------------------------------------------------------------
    initial
    begin
        int r;
        int len;
        out_stall = 1'b0;
        forever
        begin
            r = $urandom_range(0, 99);
            if (quiet || r < 55)
            begin
                out_stall = 1'b0;
                len = $urandom_range(1, 10);
            end
            else if (r < 95)
            begin
                out_stall = 1'b1;
                len = $urandom_range(1, 3);
            end
            else
            begin
                out_stall = 1'b1;
                len = $urandom_range(15, 60);
            end
            repeat (len) @(negedge clk);
        end
    end

    // Result checker: each result transfer is matched with the oldest expectation.
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with nothing expected: status %0d address %h",
                       out_data.status, out_data.result_address);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, out_data.status);
                    error_count++;
                end
                if (out_data.result_address !== want.result_address)
                begin
                    $error("result_address: expected %h, got %h",
                           want.result_address, out_data.result_address);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: counts cycles with no transfer on either side.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("page_frame_refcount_allocator verification failed");
            $finish;
        end
    end

    // Main sequence.
    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_BASE_FRAME;
        cfg_data    = '0;
        error_count = 0;
        idle_cycles = 0;
        quiet       = 1'b0;
        zone_base   = '0;
        zone_size   = '0;
        for (int i = 0; i < MAX_PAGES; i++)
            ref_counts[i] = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_saturation();
        test_zone_extremes();
        test_zone_shrink();
        test_random();

        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("page_frame_refcount_allocator verification clean");
        else
            $display("page_frame_refcount_allocator verification failed");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/pfra_pkg.sv
rtl/core/pfra_ref_mem.sv
rtl/core/pfra_rem_unit.sv
rtl/core/page_frame_refcount_allocator.sv
tb/page_frame_refcount_allocator_test.sv
